// ===== rtl/core/brao_pkg.sv =====
`default_nettype none

package brao_pkg;

    localparam int LEN_W  = 10;
    localparam int BYTE_W = 8;

    // request codes
    localparam logic [1:0] CMD_WRITE   = 2'd0;
    localparam logic [1:0] CMD_QUERY   = 2'd1;
    localparam logic [1:0] CMD_CONSUME = 2'd2;
    localparam logic [1:0] CMD_READ    = 2'd3;

    // reply kinds
    localparam logic [1:0] KIND_WSTAT = 2'd0;
    localparam logic [1:0] KIND_SECT  = 2'd1;
    localparam logic [1:0] KIND_RDATA = 2'd2;

    // reply queue
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [1:0]        cmd;
        logic [BYTE_W-1:0] data_byte;
        logic [LEN_W-1:0]  length;
        logic              first;
        logic              last;
        logic [LEN_W-1:0]  sect_start;
        logic [LEN_W-1:0]  sect_run;
        logic [LEN_W-1:0]  sect_wrap;
        logic [LEN_W-1:0]  read_addr;
    } t_in_req;

    typedef struct packed {
        logic [1:0]        reply_kind;
        logic              status;
        logic [LEN_W-1:0]  start_offset;
        logic [LEN_W-1:0]  run_length;
        logic [LEN_W-1:0]  wrap_length;
        logic [BYTE_W-1:0] read_data;
    } t_out_rsp;

    typedef struct packed {
        logic     vld;
        t_out_rsp rsp;
    } t_push;

endpackage

`default_nettype wire

// ===== rtl/core/brao_req_if.sv =====
`default_nettype none

interface brao_req_if import brao_pkg::*; ();
    logic    valid;
    logic    ready;
    t_in_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brao_rsp_if.sv =====
`default_nettype none

interface brao_rsp_if import brao_pkg::*; ();
    logic     valid;
    logic     ready;
    t_out_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/brao_ram.sv =====
`default_nettype none

module brao_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== rtl/core/brao_front.sv =====
`default_nettype none

module brao_front import brao_pkg::*; #(
    parameter int RING_SIZE = 1024
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    brao_req_if.sink        i_req,
    input  logic            i_room,
    output t_push           o_push
);

    localparam int AW = $clog2(RING_SIZE);
    localparam int CW = ((AW > LEN_W) ? AW : LEN_W) + 1;
    localparam int SW = CW + 2;

    logic [AW-1:0]    r_head, n_head;
    logic [AW-1:0]    r_tail, n_tail;
    logic [LEN_W-1:0] r_off, n_off;
    logic             r_drop, n_drop;

    logic             r_p_vld, n_p_vld;
    logic             r_p_rd, n_p_rd;
    t_out_rsp         r_p, n_p;

    logic             acc;
    logic [AW-1:0]    free, cnt;
    logic [AW:0]      end_sp, to_end;
    logic [CW-1:0]    len_x, run_x, wrap_x, tail_x, off_x, rda_x;
    logic [SW-1:0]    sum_x;
    logic             drop_eff, store, short;
    logic [LEN_W-1:0] off_eff;
    logic             we;
    logic [AW-1:0]    waddr, raddr;
    logic [BYTE_W-1:0] rdata;

    assign i_req.ready = i_room;
    assign acc = i_req.valid & i_room;

    assign len_x   = CW'(i_req.data.length);
    assign free    = r_tail - r_head - AW'(1);
    assign cnt     = r_head - r_tail;
    assign drop_eff = i_req.data.first ? (CW'(free) < len_x) : r_drop;
    assign off_eff = i_req.data.first ? '0 : r_off;
    assign store   = !drop_eff && (off_eff < i_req.data.length);
    assign off_x   = CW'(off_eff);
    assign waddr   = r_head + off_x[AW-1:0];
    assign rda_x   = CW'(i_req.data.read_addr);
    assign raddr   = rda_x[AW-1:0];

    assign short   = CW'(cnt) < len_x;
    assign end_sp  = (AW+1)'(RING_SIZE) - {1'b0, r_tail};
    assign to_end  = ({1'b0, cnt} < end_sp) ? {1'b0, cnt} : end_sp;
    assign run_x   = (len_x < CW'(to_end)) ? len_x : CW'(to_end);
    assign wrap_x  = len_x - run_x;
    assign tail_x  = CW'(r_tail);
    assign sum_x   = SW'(i_req.data.sect_start) + SW'(i_req.data.sect_run)
                   + SW'(i_req.data.sect_wrap);

    always_comb begin
        n_head  = r_head;
        n_tail  = r_tail;
        n_off   = r_off;
        n_drop  = r_drop;
        n_p_vld = 1'b0;
        n_p_rd  = 1'b0;
        n_p     = '0;
        we      = 1'b0;
        if (acc) begin
            unique case (i_req.data.cmd)
                CMD_WRITE: begin
                    we     = store;
                    n_drop = drop_eff;
                    n_off  = store ? off_eff + LEN_W'(1) : off_eff;
                    if (i_req.data.last) begin
                        if (!drop_eff) begin
                            n_head = r_head + len_x[AW-1:0];
                        end
                        n_p_vld      = 1'b1;
                        n_p.reply_kind = KIND_WSTAT;
                        n_p.status   = drop_eff;
                    end
                end
                CMD_QUERY: begin
                    n_p_vld        = 1'b1;
                    n_p.reply_kind = KIND_SECT;
                    n_p.status     = short;
                    if (!short) begin
                        n_p.start_offset = tail_x[LEN_W-1:0];
                        n_p.run_length   = run_x[LEN_W-1:0];
                        n_p.wrap_length  = wrap_x[LEN_W-1:0];
                    end
                end
                CMD_CONSUME: begin
                    n_tail = sum_x[AW-1:0];
                end
                CMD_READ: begin
                    n_p_vld        = 1'b1;
                    n_p_rd         = 1'b1;
                    n_p.reply_kind = KIND_RDATA;
                end
                default: begin
                    n_p_vld = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_off   <= '0;
            r_drop  <= 1'b0;
            r_p_vld <= 1'b0;
        end else begin
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_off   <= n_off;
            r_drop  <= n_drop;
            r_p_vld <= n_p_vld;
        end
        r_p_rd <= n_p_rd;
        r_p    <= n_p;
    end

    brao_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (RING_SIZE)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_req.data.data_byte),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_comb begin
        o_push.vld = r_p_vld;
        o_push.rsp = r_p;
        if (r_p_rd) begin
            o_push.rsp.read_data = rdata;
        end
    end

`ifndef SYNTH
    a_push_follows_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld |-> $past(acc))
        else $error("reply staged without an accepted request");

    a_dropped_keeps_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && i_req.data.cmd == CMD_WRITE && drop_eff) |=> r_head == $past(r_head))
        else $error("dropped burst moved head");

    a_no_store_when_dropped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        we |-> (!drop_eff && acc))
        else $error("ring written for a dropped burst");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/brao_queue.sv =====
`default_nettype none

module brao_queue import brao_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_push      i_push,
    output logic       o_room,
    brao_rsp_if.source o_rsp
);

    t_out_rsp        r_q [Q_DEPTH];
    logic [Q_AW-1:0] r_wr, r_rd;
    logic [Q_CW-1:0] r_count;
    logic            pop;

    assign pop         = o_rsp.valid & o_rsp.ready;
    assign o_rsp.valid = r_count != '0;
    assign o_rsp.data  = r_q[r_rd];
    // one reply may already be staged in front of the queue
    assign o_room      = r_count < Q_CW'(Q_DEPTH - 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push.vld) begin
                r_wr <= r_wr + Q_AW'(1);
            end
            if (pop) begin
                r_rd <= r_rd + Q_AW'(1);
            end
            if (i_push.vld && !pop) begin
                r_count <= r_count + Q_CW'(1);
            end else if (pop && !i_push.vld) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
        if (i_push.vld) begin
            r_q[r_wr] <= i_push.rsp;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= Q_CW'(Q_DEPTH))
        else $error("reply queue over depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push.vld && !pop) |-> r_count < Q_CW'(Q_DEPTH))
        else $error("push into full reply queue");

    a_room_reserve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_room |=> r_count < Q_CW'(Q_DEPTH))
        else $error("room granted without reserve for staged reply");
`endif

endmodule

`default_nettype wire

// ===== rtl/core/byte_ring_all_or_nothing_top.sv =====
// Channel   Dir  Modport  Payload    Note
// i_req     in   sink     t_in_req   write byte / query / consume / read request
// o_rsp     out  source   t_out_rsp  write status, section answer or read byte
//
// One request per cycle while ready is high; each reply is staged, then queued.
// The reply queue holds four entries; ready falls while it holds three or more.
// Ring storage is one RAM, registered read port, read in the cycle after request.
// Reset is synchronous: head, tail, burst state and queue cleared; RAM untouched.
// A stalled reply side fills the queue, then holds off new requests.
`default_nettype none

module byte_ring_all_or_nothing_top import brao_pkg::*; #(
    parameter int RING_SIZE = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    brao_req_if.sink   i_req,
    brao_rsp_if.source o_rsp
);

    t_push push;
    logic  room;

    brao_front #(
        .RING_SIZE (RING_SIZE)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_room  (room),
        .o_push  (push)
    );

    brao_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_rsp   (o_rsp)
    );

endmodule

`default_nettype wire
